// ===== sv/tmwc_pkg.sv =====
package tmwc_pkg;

  // Field and register widths that the interface fixes.
  localparam int SAMPLE_W        = 24;
  localparam int DEF_SAMPLE_BITS = 24;
  localparam int TARE_W          = 32;
  localparam int SCALE_W         = 24;
  localparam int WEIGHT_W        = 38;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 32;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TARE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRODUCE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VERIFY  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNIT    = 3'd4;

  // Samples per group and the fill counter.
  localparam int                  FILL_W     = 3;
  localparam logic [FILL_W-1:0]   GROUP_LAST = 3'd4;

  // Net value is 33 bits signed, so the divider numerator 20*|net| + s is 37 bits.
  localparam int NET_W   = TARE_W + 1;
  localparam int MAG_W   = TARE_W;
  localparam int NUM_W   = MAG_W + 5;
  localparam int DEN_W   = SCALE_W + 1;
  localparam int CNT_W   = 6;
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(NUM_W - 1);

  // Multiplier stage: quotient times a 32-bit unit factor, split in two halves.
  localparam int MULT_W  = 32;
  localparam int LO_W    = 19;
  localparam int HI_W    = NUM_W - LO_W;
  localparam int ACC_W   = NUM_W + MULT_W;
  localparam logic [MULT_W-1:0] MULT_LB = 32'd242400532;
  localparam logic [MULT_W-1:0] MULT_OZ = 32'd3878417316;

  typedef struct packed {
    logic acc_en;
    logic acc_first;
    logic third;
    logic mean;
    logic net;
    logic mag;
    logic load;
    logic div_step;
    logic mul_lo;
    logic mul_hi;
    logic load_out;
  } tmwc_cmd_t;

  typedef struct packed {
    logic below;
    logic out_free;
  } tmwc_sts_t;

endpackage

// ===== sv/tmwc_ctrl.sv =====
module tmwc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  tmwc_pkg::tmwc_sts_t sts_i,
  output tmwc_pkg::tmwc_cmd_t cmd_o
);
  import tmwc_pkg::*;

  localparam logic [3:0] S_COLLECT = 4'd0;
  localparam logic [3:0] S_THIRD   = 4'd1;
  localparam logic [3:0] S_MEAN    = 4'd2;
  localparam logic [3:0] S_NET     = 4'd3;
  localparam logic [3:0] S_MAG     = 4'd4;
  localparam logic [3:0] S_LOAD    = 4'd5;
  localparam logic [3:0] S_DIV     = 4'd6;
  localparam logic [3:0] S_MUL_LO  = 4'd7;
  localparam logic [3:0] S_MUL_HI  = 4'd8;
  localparam logic [3:0] S_ROUND   = 4'd9;

  logic [3:0]        state_q, state_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              accept;

  assign in_stall_o = (state_q != S_COLLECT);
  assign accept     = in_valid_i && (state_q == S_COLLECT);

  always_comb begin
    cmd_o           = '0;
    cmd_o.acc_en    = accept;
    cmd_o.acc_first = (fill_q == '0);
    cmd_o.third     = (state_q == S_THIRD);
    cmd_o.mean      = (state_q == S_MEAN);
    cmd_o.net       = (state_q == S_NET);
    cmd_o.mag       = (state_q == S_MAG);
    cmd_o.load      = (state_q == S_LOAD);
    cmd_o.div_step  = (state_q == S_DIV);
    cmd_o.mul_lo    = (state_q == S_MUL_LO);
    cmd_o.mul_hi    = (state_q == S_MUL_HI);
    cmd_o.load_out  = (state_q == S_ROUND) && sts_i.out_free;
  end

  always_comb begin
    state_d = state_q;
    fill_d  = fill_q;
    cnt_d   = cnt_q;
    case (state_q)
      S_COLLECT: begin
        if (accept) begin
          if (fill_q == GROUP_LAST) begin
            fill_d  = '0;
            state_d = S_THIRD;
          end else begin
            fill_d = fill_q + FILL_W'(1);
          end
        end
      end
      S_THIRD:  state_d = S_MEAN;
      S_MEAN:   state_d = S_NET;
      S_NET:    state_d = S_MAG;
      S_MAG:    state_d = S_LOAD;
      S_LOAD: begin
        cnt_d   = '0;
        state_d = sts_i.below ? S_ROUND : S_DIV;
      end
      S_DIV: begin
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == DIV_LAST) begin
          state_d = S_MUL_LO;
        end
      end
      S_MUL_LO: state_d = S_MUL_HI;
      S_MUL_HI: state_d = S_ROUND;
      S_ROUND: begin
        if (sts_i.out_free) begin
          state_d = S_COLLECT;
        end
      end
      default:  state_d = S_COLLECT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_COLLECT;
      fill_q  <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ===== sv/tmwc_dp.sv =====
module tmwc_dp #(
  parameter int SAMPLE_BITS = tmwc_pkg::DEF_SAMPLE_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [tmwc_pkg::SAMPLE_W-1:0]       sample_i,
  input  logic                                cfg_we_i,
  input  logic [tmwc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [tmwc_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  tmwc_pkg::tmwc_cmd_t                 cmd_i,
  output tmwc_pkg::tmwc_sts_t                 sts_o,
  input  logic                                out_stall_i,
  output logic                                out_valid_o,
  output logic [tmwc_pkg::SAMPLE_W-1:0]       trimmed_mean_o,
  output logic [tmwc_pkg::WEIGHT_W-1:0]       weight_o
);
  import tmwc_pkg::*;

  localparam int SB     = SAMPLE_BITS;
  localparam int SUM_W  = SB + 3;
  localparam int MID_W  = SB + 1;
  localparam int SHIFT  = SB + 2;
  localparam int PROD_W = 2 * SB + 2;
  // Reciprocal of three, exact for magnitudes below 2^(SB+1).
  localparam logic [MID_W-1:0] RECIP = MID_W'(((2 ** SHIFT) + 2) / 3);

  // Configuration registers.
  logic signed [TARE_W-1:0] tare_q;
  logic [SCALE_W-1:0]       produce_q;
  logic [SCALE_W-1:0]       verify_q;
  logic                     scale_sel_q;
  logic                     unit_q;

  // Group accumulators: running sum, minimum and maximum.
  logic signed [SB-1:0]     x_s;
  logic signed [SUM_W-1:0]  sum_q;
  logic signed [SB-1:0]     min_q, max_q;

  logic signed [SUM_W-1:0]  mid;
  logic [SUM_W-1:0]         mid_abs;
  logic [PROD_W-1:0]        prod_q;
  logic                     neg_q;
  logic [SB-1:0]            third_q;
  logic signed [SB-1:0]     mean_s;
  logic signed [SAMPLE_W-1:0] mean_q;
  logic signed [NET_W-1:0]  net_d, net_q;
  logic [MAG_W-1:0]         mag_q;

  logic [SCALE_W-1:0]       sel_scale, s_eff;
  logic [SCALE_W+1:0]       three_s;
  logic                     below_q;

  // Restoring divider.
  logic [DEN_W-1:0]         den_q;
  logic [DEN_W-1:0]         rem_q;
  logic [NUM_W-1:0]         quo_q;
  logic [DEN_W:0]           trial;
  logic [DEN_W+1:0]         diff;

  logic [MULT_W-1:0]        mult;
  logic [LO_W+MULT_W-1:0]   p_lo;
  logic [HI_W+MULT_W-1:0]   p_hi;
  logic [ACC_W-1:0]         acc_q;
  logic [ACC_W-1:0]         rnd;
  logic [WEIGHT_W-1:0]      weight_d;

  logic                     out_valid_q;
  logic [SAMPLE_W-1:0]      out_mean_q;
  logic [WEIGHT_W-1:0]      out_weight_q;

  assign x_s = sample_i[SB-1:0];

  always_comb begin
    mid     = sum_q - SUM_W'(min_q) - SUM_W'(max_q);
    mid_abs = mid[SUM_W-1] ? -mid : mid;
    third_q = prod_q[SHIFT +: SB];
    mean_s  = neg_q ? -third_q : third_q;
    net_d   = (NET_W'(mean_q) <<< 8) - NET_W'(tare_q);

    sel_scale = scale_sel_q ? verify_q : produce_q;
    s_eff     = (sel_scale == '0) ? SCALE_W'(1) : sel_scale;
    three_s   = {1'b0, s_eff, 1'b0} + (SCALE_W + 2)'(s_eff);

    trial = {rem_q, quo_q[NUM_W-1]};
    diff  = {1'b0, trial} - (DEN_W + 2)'(den_q);

    mult = unit_q ? MULT_OZ : MULT_LB;
    p_lo = (LO_W + MULT_W)'(quo_q[LO_W-1:0]) * (LO_W + MULT_W)'(mult);
    p_hi = (HI_W + MULT_W)'(quo_q[NUM_W-1:LO_W]) * (HI_W + MULT_W)'(mult);

    // Any bit at or above 2^38 after rounding saturates the weight.
    rnd = acc_q + (ACC_W'(1) << 23);
    if (below_q) begin
      weight_d = '0;
    end else if (|rnd[ACC_W-1:WEIGHT_W+24]) begin
      weight_d = '1;
    end else begin
      weight_d = rnd[WEIGHT_W+23:24];
    end
  end

  assign sts_o.below    = ({1'b0, mag_q} < (MAG_W + 1)'(three_s));
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tare_q      <= '0;
      produce_q   <= SCALE_W'(256);
      verify_q    <= SCALE_W'(256);
      scale_sel_q <= 1'b0;
      unit_q      <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_TARE:    tare_q      <= cfg_data_i[TARE_W-1:0];
        CFG_PRODUCE: produce_q   <= cfg_data_i[SCALE_W-1:0];
        CFG_VERIFY:  verify_q    <= cfg_data_i[SCALE_W-1:0];
        CFG_SCALE:   scale_sel_q <= cfg_data_i[0];
        CFG_UNIT:    unit_q      <= cfg_data_i[0];
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_en) begin
      sum_q <= cmd_i.acc_first ? SUM_W'(x_s) : sum_q + SUM_W'(x_s);
      min_q <= (cmd_i.acc_first || (x_s < min_q)) ? x_s : min_q;
      max_q <= (cmd_i.acc_first || (x_s > max_q)) ? x_s : max_q;
    end
    if (cmd_i.third) begin
      prod_q <= PROD_W'(mid_abs[MID_W-1:0]) * PROD_W'(RECIP);
      neg_q  <= mid[SUM_W-1];
    end
    if (cmd_i.mean) begin
      mean_q <= SAMPLE_W'(mean_s);
    end
    if (cmd_i.net) begin
      net_q <= net_d;
    end
    if (cmd_i.mag) begin
      mag_q <= net_q[NET_W-1] ? MAG_W'(-net_q) : net_q[MAG_W-1:0];
    end
    if (cmd_i.load) begin
      below_q <= sts_o.below;
      den_q   <= {s_eff, 1'b0};
      rem_q   <= '0;
      quo_q   <= (NUM_W'(mag_q) << 4) + (NUM_W'(mag_q) << 2) + NUM_W'(s_eff);
    end
    if (cmd_i.div_step) begin
      rem_q <= diff[DEN_W+1] ? trial[DEN_W-1:0] : diff[DEN_W-1:0];
      quo_q <= {quo_q[NUM_W-2:0], !diff[DEN_W+1]};
    end
    if (cmd_i.mul_lo) begin
      acc_q <= ACC_W'(p_lo);
    end
    if (cmd_i.mul_hi) begin
      acc_q <= acc_q + {p_hi, {LO_W{1'b0}}};
    end
    if (cmd_i.load_out) begin
      out_mean_q   <= mean_q;
      out_weight_q <= weight_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign trimmed_mean_o = out_mean_q;
  assign weight_o       = out_weight_q;

endmodule

// ===== sv/trimmed_mean_weight_converter_unit.sv =====
// Trimmed-mean weight converter.
// Input channel: in_valid_i / in_stall_o carry one signed load-cell sample per request.
// Samples form groups of five. The first four requests of a group are taken without
// a stall and produce nothing. The fifth closes the group and starts the result path.
// Output channel: out_valid_o / out_stall_i carry trimmed_mean_o and weight_o.
// The result path runs through the 37-step restoring divider, one quotient bit per
// cycle, and the multiplier; when the magnitude is below the 3 g threshold both are
// skipped and the weight is zero.
// in_stall_o is high while a group is being converted.
// The result sits in an output register. When the receiver stalls it holds there and
// the next group's samples are still taken; only a second finished result waits for
// the register to free up.
// Configuration is written by the user through cfg_we_i / cfg_index_i / cfg_data_i while idle;
// the block does not enforce this. Reset clears the group counter and the output valid, and
// returns the registers to zero tare, a scale of 256 for both scales, produce scale and pounds.
module trimmed_mean_weight_converter_unit #(
  parameter int SAMPLE_BITS = tmwc_pkg::DEF_SAMPLE_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [tmwc_pkg::SAMPLE_W-1:0]   sample_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [tmwc_pkg::SAMPLE_W-1:0]   trimmed_mean_o,
  output logic [tmwc_pkg::WEIGHT_W-1:0]   weight_o,
  input  logic                            cfg_we_i,
  input  logic [tmwc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tmwc_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import tmwc_pkg::*;

  tmwc_cmd_t cmd;
  tmwc_sts_t sts;

  // The controller sequences the group count, the divide steps and the result hand-off.
  tmwc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // The datapath holds the configuration, the accumulators, the divider and the output register.
  tmwc_dp #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .sample_i       (sample_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .trimmed_mean_o (trimmed_mean_o),
    .weight_o       (weight_o)
  );

  // A result is only loaded when the output register is free to take it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> sts.out_free)
    else $error("result loaded over an unconsumed result");

  // The output valid only rises after a result load.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd.load_out))
    else $error("output valid rose without a result load");

  // No sample is taken while the divider or multiplier is working.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.div_step || cmd.mul_lo || cmd.mul_hi) |-> (in_stall_o && !cmd.acc_en))
    else $error("sample taken during conversion");

endmodule

// ===== bench/trimmed_mean_weight_converter_unit_tb.sv =====
`timescale 1ns / 100ps

// The testbench for the trimmed-mean weight converter.
// The driver sends sample requests from a queue that the stimulus process fills.
// Every accepted sample also goes into a copy of the five-sample group kept here.
// When a group closes, the expected trimmed mean and weight are computed from that
// copy and the current register values. The monitor compares each result request
// with the oldest expected reading, field by field.
module trimmed_mean_weight_converter_unit_tb;
  import tmwc_pkg::*;

  // Cycles of quiet after the last expected reading. This covers a conversion
  // with margin. It matters because a partial group gives no result.
  localparam int SETTLE_CYCLES  = 60;
  localparam int PHASE_SAMPLES  = 185;
  localparam int RANDOM_PHASES  = 10;
  localparam int HOLD_CYCLES    = 400;
  localparam longint unsigned WEIGHT_MAX = (64'd1 << WEIGHT_W) - 64'd1;

  typedef struct packed {
    logic [SAMPLE_W-1:0] mean;
    logic [WEIGHT_W-1:0] weight;
  } reading_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  logic [SAMPLE_W-1:0]   sample_i    = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [SAMPLE_W-1:0]   trimmed_mean_o;
  logic [WEIGHT_W-1:0]   weight_o;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  // These are the samples still to be sent and the readings still to arrive.
  logic [SAMPLE_W-1:0] pending_samples [$];
  reading_t            expected_readings [$];

  // This is the local copy of the register file, starting at the reset values.
  longint          tare_q      = 0;
  longint unsigned produce_cpg = 256;
  longint unsigned verify_cpg  = 256;
  logic            scale_sel   = 1'b0;
  logic            unit_oz     = 1'b0;

  // This is the local copy of the group being filled.
  longint group_buf [5];
  int     group_count = 0;

  // The stimulus process sets these idle rates, in percent per cycle.
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  logic hold_off       = 1'b0;
  logic pressure_go    = 1'b0;

  int samples_taken   = 0;
  int readings_seen   = 0;
  int mismatches      = 0;
  int settings_used   = 1;

  reading_t want;

  trimmed_mean_weight_converter_unit u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .sample_i       (sample_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .trimmed_mean_o (trimmed_mean_o),
    .weight_o       (weight_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // This sorts the closed group and takes the mean of the middle three, truncated
  // toward zero. It then subtracts the tare, scales the magnitude to tenths of a
  // gram and converts to the chosen unit in Q.16, zero below 3 g and saturating.
  function automatic reading_t convert_group();
    longint          srt [5];
    longint          key, mean, net;
    longint unsigned mag, s, mult, tenths, w;
    int              i, j;
    reading_t        r;
    for (i = 0; i < 5; i++) srt[i] = group_buf[i];
    for (i = 1; i < 5; i++) begin
      key = srt[i];
      j = i - 1;
      while (j >= 0 && srt[j] > key) begin
        srt[j + 1] = srt[j];
        j--;
      end
      srt[j + 1] = key;
    end
    mean = (srt[1] + srt[2] + srt[3]) / 3;
    net  = mean * 256 - tare_q;
    mag  = (net < 0) ? -net : net;
    s    = scale_sel ? verify_cpg : produce_cpg;
    if (s == 0) s = 1;
    mult = unit_oz ? MULT_OZ : MULT_LB;
    if (mag < 3 * s) begin
      w = 0;
    end else begin
      tenths = (20 * mag + s) / (2 * s);
      // The product no longer fits in 64 bits, so it is far past the top of the range.
      if (tenths > (64'hFFFF_FFFF_FFFF_FFFF - 64'h80_0000) / mult) begin
        w = WEIGHT_MAX;
      end else begin
        w = (tenths * mult + 64'h80_0000) >> 24;
        if (w > WEIGHT_MAX) w = WEIGHT_MAX;
      end
    end
    r.mean   = mean[SAMPLE_W-1:0];
    r.weight = w[WEIGHT_W-1:0];
    return r;
  endfunction

  function automatic void record_sample(input logic [SAMPLE_W-1:0] smp);
    group_buf[group_count] = longint'($signed(smp));
    group_count++;
    if (group_count == 5) begin
      group_count = 0;
      expected_readings.push_back(convert_group());
    end
  endfunction

  function automatic longint rand_sample();
    logic [SAMPLE_W-1:0] raw;
    raw = SAMPLE_W'($urandom);
    return longint'($signed(raw));
  endfunction

  // This queues one group of five with random content. Half the groups are steady
  // readings with a little noise. Some sit near the 3 g threshold for the current
  // tare and scale. The rest are fully random, spiky, or five equal values.
  task automatic push_group();
    longint          center, span, v, sc;
    int              kind, spike, i;
    kind  = $urandom_range(9);
    spike = $urandom_range(4);
    sc    = scale_sel ? verify_cpg : produce_cpg;
    if (kind == 5 || kind == 6) begin
      center = tare_q / 256;
      span   = sc * 4 / 256 + 2;
    end else begin
      center = rand_sample();
      span   = (kind == 9) ? 0 : $urandom_range(64);
    end
    for (i = 0; i < 5; i++) begin
      if (kind == 7 || (kind == 8 && i == spike)) begin
        v = rand_sample();
      end else begin
        v = center - span + longint'($urandom_range(32'(2 * span)));
      end
      if (v > 64'sd8388607) v = 64'sd8388607;
      if (v < -64'sd8388608) v = -64'sd8388608;
      pending_samples.push_back(v[SAMPLE_W-1:0]);
    end
  endtask

  // A register write takes one cycle with the write enable high. The local copy
  // follows at once; nothing is converting while registers change.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      CFG_TARE:    tare_q      = longint'($signed(val));
      CFG_PRODUCE: produce_cpg = val[SCALE_W-1:0];
      CFG_VERIFY:  verify_cpg  = val[SCALE_W-1:0];
      CFG_SCALE:   scale_sel   = val[0];
      CFG_UNIT:    unit_oz     = val[0];
      default: ;
    endcase
  endtask

  // Wait until every queued sample has gone out and every reading has come back.
  // A partial group may still be in the block, so let it settle before a write.
  task automatic wait_idle();
    while (pending_samples.size() != 0 || in_valid_i || expected_readings.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // The driver offers the next sample once the current request is taken. When it
  // has nothing to send, or when it idles, it lowers valid. A held request keeps its
  // payload until the block takes it.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        record_sample(sample_i);
        samples_taken++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          sample_i   <= pending_samples.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // The monitor checks each accepted result request against the oldest expected
  // reading. Stalls come at random, or without a break during the long hold-off.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        readings_seen++;
        if (expected_readings.size() == 0) begin
          if (mismatches < 10)
            $display("ERROR: reading with nothing expected: mean %0d weight 0x%0h",
                     $signed(trimmed_mean_o), weight_o);
          mismatches++;
        end else begin
          want = expected_readings.pop_front();
          if (want.mean !== trimmed_mean_o || want.weight !== weight_o) begin
            if (mismatches < 10)
              $display("ERROR: mean exp %0d got %0d, weight exp 0x%0h got 0x%0h",
                       $signed(want.mean), $signed(trimmed_mean_o), want.weight, weight_o);
            mismatches++;
          end
        end
      end
      out_stall_i <= hold_off || ($urandom_range(99) < recv_stall_pct);
    end
  end

  // The long receiver hold-off is counted here. The sender keeps offering samples
  // meanwhile, so the output register and the second finished result fill up and
  // the block has to stall its input.
  initial begin
    wait (pressure_go);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    logic [SAMPLE_W-1:0] directed [25];
    int p, n;
    // The directed groups run at the reset registers. There are five full-scale
    // readings, then five at the most negative value. Next comes an unsorted mix
    // of both extremes with a mean of zero. After that, duplicates whose negative
    // sum does not divide by three, so the mean truncates toward zero. Last, a
    // group whose mean lands exactly on the 3 g threshold.
    directed = '{24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF,
                 24'h800000, 24'h800000, 24'h800000, 24'h800000, 24'h800000,
                 24'h7FFFFF, 24'h800000, 24'd5,      24'hFFFFF9, 24'd3,
                 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFE, 24'h800000, 24'h7FFFFF,
                 24'd3,      24'd100,    24'd3,      24'd0,      24'd3};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (n = 0; n < 25; n++) pending_samples.push_back(directed[n]);
    wait_idle();

    for (p = 0; p < RANDOM_PHASES; p++) begin
      // The first setting mixes maximum tare, the smallest scale and ounces, which
      // drives weights into saturation. The second takes minimum tare and selects a
      // verify scale of one. The third has the reset tare, produce scale and unit but
      // selects a verify scale of 116224. Later settings are random.
      case (p)
        0: begin
          write_reg(CFG_TARE, 32'h7FFF_FFFF);
          write_reg(CFG_PRODUCE, 32'd1);
          write_reg(CFG_VERIFY, 32'hFF_FFFF);
          write_reg(CFG_SCALE, 32'd0);
          write_reg(CFG_UNIT, 32'd1);
        end
        1: begin
          write_reg(CFG_TARE, 32'h8000_0000);
          write_reg(CFG_PRODUCE, 32'hFF_FFFF);
          write_reg(CFG_VERIFY, 32'd1);
          write_reg(CFG_SCALE, 32'd1);
          write_reg(CFG_UNIT, 32'd0);
        end
        2: begin
          write_reg(CFG_TARE, 32'd0);
          write_reg(CFG_PRODUCE, 32'd256);
          write_reg(CFG_VERIFY, 32'd116224);
          write_reg(CFG_SCALE, 32'd1);
          write_reg(CFG_UNIT, 32'd0);
        end
        default: begin
          write_reg(CFG_TARE, $urandom_range(1) ? $urandom : 32'($signed($urandom_range(2_000_000)) - 1_000_000));
          write_reg(CFG_PRODUCE, $urandom_range(1) ? $urandom_range(32'hFF_FFFF, 1) : $urandom_range(4096, 1));
          write_reg(CFG_VERIFY, $urandom_range(1) ? $urandom_range(32'hFF_FFFF, 1) : $urandom_range(4096, 1));
          write_reg(CFG_SCALE, $urandom_range(1));
          write_reg(CFG_UNIT, $urandom_range(1));
        end
      endcase
      settings_used++;
      // The idle mixes rotate: none, the sender, the receiver, then both.
      case (p % 4)
        0: begin send_idle_pct <= 0;  recv_stall_pct <= 0;  end
        1: begin send_idle_pct <= 78; recv_stall_pct <= 0;  end
        2: begin send_idle_pct <= 0;  recv_stall_pct <= 78; end
        default: begin send_idle_pct <= 16; recv_stall_pct <= 16; end
      endcase
      for (n = 0; n + 5 <= PHASE_SAMPLES; n += 5) push_group();
      // Up to four loose samples can leave a group open across the register change.
      repeat ($urandom_range(4)) pending_samples.push_back(SAMPLE_W'($urandom));
      wait_idle();
    end

    send_idle_pct  <= 0;
    recv_stall_pct <= 0;
    pressure_go = 1'b1;
    for (n = 0; n < 60; n += 5) push_group();
    wait_idle();

    if (expected_readings.size() != 0) mismatches++;
    $display("Summary: %0d samples accepted, %0d readings checked, %0d register settings.",
             samples_taken, readings_seen, settings_used);
    $display("Summary: idle mixes for sender and receiver plus one long receiver hold-off.");
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/tmwc_pkg.sv
sv/tmwc_ctrl.sv
sv/tmwc_dp.sv
sv/trimmed_mean_weight_converter_unit.sv
bench/trimmed_mean_weight_converter_unit_tb.sv
